@@ sv/fau_pkg.sv @@
package fau_pkg;

  localparam int unsigned OperandWidthDef = 16;
  localparam int unsigned ResNumWidth     = 48;
  localparam int unsigned ResDenWidth     = 32;
  localparam int unsigned OpWidth         = 2;

  typedef enum logic [OpWidth-1:0] {
    OpAdd = 2'd0,
    OpSub = 2'd1,
    OpMul = 2'd2,
    OpDiv = 2'd3
  } op_e;

  typedef enum logic {
    StatusOk      = 1'b0,
    StatusDivZero = 1'b1
  } status_e;

endpackage

@@ sv/fau_divider.sv @@
// Restoring divider, one quotient bit per cycle, truncating toward zero.
// The remainder takes the sign of the dividend, the quotient is negative when
// the operand signs differ. The divisor must be nonzero.
module fau_divider #(
  parameter int unsigned Width = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [Width-1:0] dividend_i,
  input  logic signed [Width-1:0] divisor_i,
  output logic                    done_o,
  output logic signed [Width-1:0] quot_o,
  output logic signed [Width-1:0] rem_o
);
  import fau_pkg::*;

  localparam int unsigned CntWidth = $clog2(Width + 1);

  logic [Width-1:0]    dvd_q, dvd_d;
  logic [Width-1:0]    dvs_q, dvs_d;
  logic [Width:0]      rem_q, rem_d;
  logic [CntWidth-1:0] cnt_q, cnt_d;
  logic                run_q, run_d;
  logic                qneg_q, qneg_d, rneg_q, rneg_d;
  logic                done_q, done_d;
  logic [Width:0]      trial;
  logic [Width:0]      shifted;

  always_comb begin
    shifted = {rem_q[Width-1:0], dvd_q[Width-1]};
    trial   = shifted - {1'b0, dvs_q};
  end

  always_comb begin
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    qneg_d = qneg_q;
    rneg_d = rneg_q;
    done_d = 1'b0;
    if (start_i) begin
      dvd_d  = dividend_i[Width-1] ? Width'(-dividend_i) : dividend_i;
      dvs_d  = divisor_i[Width-1] ? Width'(-divisor_i) : divisor_i;
      rem_d  = '0;
      cnt_d  = CntWidth'(Width);
      run_d  = 1'b1;
      qneg_d = dividend_i[Width-1] ^ divisor_i[Width-1];
      rneg_d = dividend_i[Width-1];
    end else if (run_q) begin
      if (!trial[Width]) begin
        rem_d = trial;
        dvd_d = {dvd_q[Width-2:0], 1'b1};
      end else begin
        rem_d = shifted;
        dvd_d = {dvd_q[Width-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntWidth'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q  <= dvd_d;
    dvs_q  <= dvs_d;
    rem_q  <= rem_d;
    qneg_q <= qneg_d;
    rneg_q <= rneg_d;
  end

  assign done_o = done_q;
  assign quot_o = qneg_q ? Width'(-dvd_q) : dvd_q;
  assign rem_o  = rneg_q ? Width'(-rem_q[Width-1:0]) : rem_q[Width-1:0];

endmodule

@@ sv/fraction_arithmetic_unit_top.sv @@
// Channel  | Handshake        | Payload
// ---------+------------------+------------------------------------------
// command  | start_i, busy_o  | operation_i, a_num_i, a_den_i, b_num_i, b_den_i
// result   | res_valid_o      | res_num_o, res_den_o, status_o
//
// A command beat is taken when start_i is high and busy_o is low; busy_o
// stays high until the result beat has been shown for its single cycle.
// Every gcd step and every exact division runs on one shared iterative
// divider of OPERAND_WIDTH+1 bits. Add/sub needs one gcd chain, mul/div two
// (each at most about 1.5*OPERAND_WIDTH steps), plus two or four exact
// divisions, and the product states StMul1 and StMul2 on the multiplier.
// Reset clears the sequencer only; the result port cannot stall.
module fraction_arithmetic_unit_top #(
  parameter int unsigned OPERAND_WIDTH = fau_pkg::OperandWidthDef
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    start_i,
  output logic                                    busy_o,
  input  logic [fau_pkg::OpWidth-1:0]             operation_i,
  input  logic signed [OPERAND_WIDTH-1:0]         a_num_i,
  input  logic signed [OPERAND_WIDTH-1:0]         a_den_i,
  input  logic signed [OPERAND_WIDTH-1:0]         b_num_i,
  input  logic signed [OPERAND_WIDTH-1:0]         b_den_i,
  output logic                                    res_valid_o,
  output logic signed [fau_pkg::ResNumWidth-1:0]  res_num_o,
  output logic signed [fau_pkg::ResDenWidth-1:0]  res_den_o,
  output logic                                    status_o
);
  import fau_pkg::*;

  // One extra bit holds the magnitude of the most negative operand, so that
  // a gcd of it (which can come out positive) and its quotients never wrap.
  localparam int unsigned W  = OPERAND_WIDTH + 1;
  localparam int unsigned PW = 2 * W;

  typedef enum logic [3:0] {
    StIdle, StG1Start, StG1Wait, StG2Start, StG2Wait,
    StQStart, StQWait, StMul1, StMul2, StOut
  } state_e;

  state_e            state_q;
  op_e               op_q;
  logic signed [W-1:0] an_q, ad_q, bn_q, bd_q;
  logic signed [W-1:0] gx_q, gy_q, g1_q, g2_q;
  logic signed [W-1:0] q_q [4];
  logic [1:0]        qi_q;
  logic signed [PW-1:0] p1_q, p2_q;
  logic signed [ResNumWidth-1:0] num_q;
  logic signed [ResDenWidth-1:0] den_q;
  logic              err_q, valid_q;

  logic              div_start;
  logic signed [W-1:0] div_a, div_b, div_quot, div_rem;
  logic              div_done;
  logic              addsub;

  assign addsub = (op_q == OpAdd) || (op_q == OpSub);

  fau_divider #(.Width(W)) u_div (
    .clk_i, .rst_ni,
    .start_i(div_start), .dividend_i(div_a), .divisor_i(div_b),
    .done_o(div_done), .quot_o(div_quot), .rem_o(div_rem)
  );

  // Quotient jobs: add/sub needs bd/g and ad/g; mul/div needs pn/f1, qn/f2,
  // pd/f2, qd/f1, with the operands already swapped for divide.
  always_comb begin
    div_start = 1'b0;
    div_a = gx_q;
    div_b = gy_q;
    if (state_q == StQStart) begin
      div_start = 1'b1;
      if (addsub) begin
        div_a = (qi_q == 2'd0) ? bd_q : ad_q;
        div_b = g1_q;
      end else begin
        unique case (qi_q)
          2'd0: begin div_a = an_q; div_b = g1_q; end
          2'd1: begin div_a = bn_q; div_b = g2_q; end
          2'd2: begin div_a = ad_q; div_b = g2_q; end
          default: begin div_a = bd_q; div_b = g1_q; end
        endcase
      end
    end else if (state_q == StG1Start || state_q == StG2Start) begin
      div_start = (gy_q != '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      valid_q <= 1'b0;
    end else begin
      valid_q <= 1'b0;
      unique case (state_q)
        StIdle: if (start_i && !busy_o) begin
          state_q <= StG1Start;
          op_q    <= op_e'(operation_i);
          an_q    <= W'(a_num_i);
          ad_q    <= W'(a_den_i);
          if (op_e'(operation_i) == OpDiv) begin
            bn_q <= W'(b_den_i);
            bd_q <= W'(b_num_i);
            gx_q <= W'(a_num_i);
            gy_q <= W'(b_num_i);
          end else begin
            bn_q <= W'(b_num_i);
            bd_q <= W'(b_den_i);
            if (op_e'(operation_i) == OpMul) begin
              gx_q <= W'(a_num_i);
              gy_q <= W'(b_den_i);
            end else begin
              gx_q <= W'(a_den_i);
              gy_q <= W'(b_den_i);
            end
          end
          err_q <= 1'b0;
          qi_q  <= '0;
        end
        StG1Start, StG2Start: begin
          if (gy_q == '0) begin
            if (state_q == StG1Start) begin
              g1_q <= gx_q;
              if (addsub) begin
                if (ad_q == '0 || bd_q == '0) begin
                  err_q   <= 1'b1;
                  state_q <= StOut;
                end else begin
                  state_q <= StQStart;
                end
              end else begin
                gx_q    <= bn_q;
                gy_q    <= ad_q;
                state_q <= StG2Start;
              end
            end else begin
              g2_q <= gx_q;
              if (g1_q == '0 || gx_q == '0) begin
                err_q   <= 1'b1;
                state_q <= StOut;
              end else begin
                state_q <= StQStart;
              end
            end
          end else begin
            state_q <= (state_q == StG1Start) ? StG1Wait : StG2Wait;
          end
        end
        StG1Wait, StG2Wait: if (div_done) begin
          gx_q    <= gy_q;
          gy_q    <= div_rem;
          state_q <= (state_q == StG1Wait) ? StG1Start : StG2Start;
        end
        StQStart: state_q <= StQWait;
        StQWait: if (div_done) begin
          q_q[qi_q] <= div_quot;
          qi_q      <= qi_q + 1'b1;
          if ((addsub && qi_q == 2'd1) || qi_q == 2'd3) begin
            state_q <= StMul1;
          end else begin
            state_q <= StQStart;
          end
        end
        StMul1: begin
          // Products are spread over StMul1 and StMul2, at most two in either state.
          if (addsub) begin
            p1_q <= PW'(an_q) * PW'(q_q[0]);
            den_q <= ResDenWidth'(PW'(ad_q) * PW'(q_q[0]));
          end else begin
            p1_q <= PW'(q_q[0]) * PW'(q_q[1]);
          end
          state_q <= StMul2;
        end
        StMul2: begin
          if (addsub) begin
            p2_q <= PW'(bn_q) * PW'(q_q[1]);
          end else begin
            den_q <= ResDenWidth'(PW'(q_q[2]) * PW'(q_q[3]));
          end
          state_q <= StOut;
        end
        StOut: begin
          if (err_q) begin
            num_q <= '0;
            den_q <= '0;
          end else if (op_q == OpAdd) begin
            num_q <= ResNumWidth'(p1_q + p2_q);
          end else if (op_q == OpSub) begin
            num_q <= ResNumWidth'(p1_q - p2_q);
          end else begin
            num_q <= ResNumWidth'(p1_q);
          end
          valid_q <= 1'b1;
          state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign busy_o      = (state_q != StIdle) || valid_q;
  assign res_valid_o = valid_q;
  assign res_num_o   = num_q;
  assign res_den_o   = den_q;
  assign status_o    = err_q;

endmodule

@@ sim/fau_checker.sv @@
`timescale 1ns / 100ps

module fau_checker
  import fau_pkg::*;
#(
  parameter int unsigned W = OperandWidthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic                          busy_i,
  input  logic [OpWidth-1:0]            operation_i,
  input  logic signed [W-1:0]           a_num_i,
  input  logic signed [W-1:0]           a_den_i,
  input  logic signed [W-1:0]           b_num_i,
  input  logic signed [W-1:0]           b_den_i,
  input  logic                          res_valid_i,
  input  logic signed [ResNumWidth-1:0] res_num_i,
  input  logic signed [ResDenWidth-1:0] res_den_i,
  input  logic                          status_i,
  output int unsigned                   err_cnt_o,
  output int unsigned                   pending_o
);

  typedef struct packed {
    logic [ResNumWidth-1:0] num;
    logic [ResDenWidth-1:0] den;
    status_e                status;
  } fraction_t;

  fraction_t fractions_due[$];

  // Euclid with truncating remainder; the sign of the result follows it.
  function automatic longint gcd_trunc(longint x, longint y);
    longint r;
    while (y != 0) begin
      r = x % y;
      x = y;
      y = r;
    end
    return x;
  endfunction

  function automatic fraction_t fraction_calc(op_e op, longint an, longint ad,
                                              longint bn, longint bd);
    fraction_t f;
    longint    g, ka, kb, qn, qd, f1, f2, num, den;
    num = 0;
    den = 0;
    f.status = StatusOk;
    if (op == OpAdd || op == OpSub) begin
      if (ad == 0 || bd == 0) begin
        f.status = StatusDivZero;
      end else begin
        g   = gcd_trunc(ad, bd);
        ka  = bd / g;
        kb  = ad / g;
        den = ad * ka;
        num = (op == OpAdd) ? an * ka + bn * kb : an * ka - bn * kb;
      end
    end else begin
      // Divide is multiply by the swapped second fraction.
      qn = (op == OpDiv) ? bd : bn;
      qd = (op == OpDiv) ? bn : bd;
      f1 = gcd_trunc(an, qd);
      f2 = gcd_trunc(qn, ad);
      if (f1 == 0 || f2 == 0) begin
        f.status = StatusDivZero;
      end else begin
        num = (an / f1) * (qn / f2);
        den = (ad / f2) * (qd / f1);
      end
    end
    f.num = num[ResNumWidth-1:0];
    f.den = den[ResDenWidth-1:0];
    return f;
  endfunction

  fraction_t got, want;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_i) begin
        fractions_due.push_back(fraction_calc(op_e'(operation_i), a_num_i, a_den_i,
                                              b_num_i, b_den_i));
      end
      if (res_valid_i) begin
        got.num    = res_num_i;
        got.den    = res_den_i;
        got.status = status_e'(status_i);
        if (fractions_due.size() == 0) begin
          err_cnt_o <= err_cnt_o + 1;
          if (err_cnt_o < 10) begin
            $display("result beat with nothing expected: num %0d den %0d st %0d",
                     res_num_i, res_den_i, status_i);
          end
        end else begin
          want = fractions_due.pop_front();
          if (got !== want) begin
            err_cnt_o <= err_cnt_o + 1;
            if (err_cnt_o < 10) begin
              $display("mismatch: exp num %0d den %0d st %0d, got num %0d den %0d st %0d",
                       $signed(want.num), $signed(want.den), want.status,
                       res_num_i, res_den_i, status_i);
            end
          end
        end
      end
    end
    pending_o <= fractions_due.size();
  end

  initial begin
    err_cnt_o = 0;
    pending_o = 0;
  end

endmodule

@@ sim/tb_fraction_arithmetic_unit_top.sv @@
`timescale 1ns / 100ps

module tb_fraction_arithmetic_unit_top;
  import fau_pkg::*;

  localparam int unsigned W         = OperandWidthDef;
  localparam int unsigned NumRandom = 1030;
  // The idle limit allows many times the longest an item can take.
  localparam int unsigned IdleLimit = 20000;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          start_i = 1'b0;
  logic                          busy_o;
  logic [OpWidth-1:0]            operation_i = '0;
  logic signed [W-1:0]           a_num_i = '0;
  logic signed [W-1:0]           a_den_i = '0;
  logic signed [W-1:0]           b_num_i = '0;
  logic signed [W-1:0]           b_den_i = '0;
  logic                          res_valid_o;
  logic signed [ResNumWidth-1:0] res_num_o;
  logic signed [ResDenWidth-1:0] res_den_o;
  logic                          status_o;
  int unsigned                   err_cnt;
  int unsigned                   pending;
  int unsigned                   stall_cycles;
  bit                            idle_en;

  // Clock with a 2 ns period.
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  fraction_arithmetic_unit_top #(.OPERAND_WIDTH(W)) dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .operation_i,
    .a_num_i, .a_den_i, .b_num_i, .b_den_i,
    .res_valid_o, .res_num_o, .res_den_o, .status_o
  );

  fau_checker #(.W(W)) u_checker (
    .clk_i, .rst_ni, .start_i, .busy_i(busy_o), .operation_i,
    .a_num_i, .a_den_i, .b_num_i, .b_den_i,
    .res_valid_i(res_valid_o), .res_num_i(res_num_o), .res_den_i(res_den_o),
    .status_i(status_o), .err_cnt_o(err_cnt), .pending_o(pending)
  );

  // The watchdog counts cycles in which neither a command beat nor a result
  // beat happens. A hung block ends the run here.
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || res_valid_o || !rst_ni) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= IdleLimit) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Operand mix: small values most often so that gcds are nontrivial, plus the
  // full range, the extremes, zero and minus one; zero drives the error paths.
  function automatic logic [W-1:0] pick_operand();
    case ($urandom_range(0, 9))
      0, 1, 2:    return W'($urandom());
      3, 4, 5, 6: return W'($signed($urandom_range(0, 40)) - 20);
      7:          return {1'b1, {(W-1){1'b0}}};
      8:          return {1'b0, {(W-1){1'b1}}};
      default:    return $urandom_range(0, 1) ? '0 : '1;
    endcase
  endfunction

  // Present one command beat and hold it until the block takes it. Start is
  // left high afterward unless idling is on and a random idle gap is drawn.
  task automatic send_cmd(op_e op, int an, int ad, int bn, int bd);
    start_i     <= 1'b1;
    operation_i <= op;
    a_num_i     <= W'(an);
    a_den_i     <= W'(ad);
    b_num_i     <= W'(bn);
    b_den_i     <= W'(bd);
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    if (idle_en && $urandom_range(0, 2) == 0) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  localparam logic [W-1:0] MinV = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] MaxV = {1'b0, {(W-1){1'b1}}};

  initial begin
    idle_en = 1'b1;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: every operation, the field extremes, zero denominators,
    // zero cancel factors and a zero result denominator without error.
    send_cmd(OpAdd, 1, 2, 1, 3);
    send_cmd(OpSub, 1, 2, 1, 3);
    send_cmd(OpMul, 2, 3, 9, 4);
    send_cmd(OpDiv, 2, 3, 9, 4);
    send_cmd(OpAdd, MaxV, MinV, MinV, MaxV);
    send_cmd(OpSub, MinV, MaxV, MaxV, MinV);
    send_cmd(OpMul, MinV, MinV, MinV, MinV);
    send_cmd(OpDiv, MinV, MaxV, MaxV, MinV);
    send_cmd(OpMul, MaxV, -1, MaxV, -1);
    send_cmd(OpDiv, -1, -1, -1, -1);
    send_cmd(OpAdd, 5, 0, 1, 3);
    send_cmd(OpSub, 5, 7, 1, 0);
    send_cmd(OpMul, 0, 3, 4, 0);
    send_cmd(OpMul, 3, 0, 0, 5);
    send_cmd(OpDiv, 0, 3, 0, 7);
    send_cmd(OpDiv, 4, 0, 5, 0);
    send_cmd(OpMul, 3, 0, 6, 5);
    send_cmd(OpDiv, 3, 5, 0, 6);
    send_cmd(OpAdd, -6, -4, 9, 6);
    send_cmd(OpSub, 0, -1, 0, 1);
    send_cmd(OpMul, -8, 12, 6, -20);

    // Random part; the last stretch runs with no idling at all.
    for (int i = 0; i < NumRandom; i++) begin
      idle_en = (i < NumRandom - 100);
      send_cmd(op_e'($urandom_range(0, 3)), pick_operand(), pick_operand(),
               pick_operand(), pick_operand());
    end
    start_i <= 1'b0;
    @(posedge clk_i);

    while (pending != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
